>>> hw/rtl/cvkf_pkg.sv
// ----------------------------------------------------------------------------
// cvkf_pkg
// Shared types, constants and fixed-point helpers of the six-axis
// constant-velocity Kalman filter.
// ----------------------------------------------------------------------------
package cvkf_pkg;

	localparam int AXES      = 6;
	localparam int LANES     = 6;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int STEP_W    = 24;
	localparam int SUM_W     = DATA_W + 4;
	localparam int OPND_W    = DATA_W + 1;
	localparam int PROD_W    = 2 * OPND_W;

	localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// configuration register indexes
	localparam logic CFG_PROCESS_NOISE = 1'b0;
	localparam logic CFG_MEASURE_NOISE = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] meas_x;
		logic signed [DATA_W-1:0] meas_y;
		logic signed [DATA_W-1:0] meas_z;
		logic signed [DATA_W-1:0] meas_roll;
		logic signed [DATA_W-1:0] meas_pitch;
		logic signed [DATA_W-1:0] meas_yaw;
		logic        [STEP_W-1:0] step_time;
		logic                     restart;
	} cvkf_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] est_x;
		logic signed [DATA_W-1:0] est_y;
		logic signed [DATA_W-1:0] est_z;
		logic signed [DATA_W-1:0] est_roll;
		logic signed [DATA_W-1:0] est_pitch;
		logic signed [DATA_W-1:0] est_yaw;
	} cvkf_out_t;

	typedef struct packed {
		logic start;
		logic init;
	} cvkf_cmd_t;

	function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(S32_MAX);
		lo = SUM_W'(S32_MIN);
		if (x > hi)
			return S32_MAX;
		else if (x < lo)
			return S32_MIN;
		else
			return x[DATA_W-1:0];
	endfunction

	// round to nearest (ties up), floor shift, saturate
	function automatic logic signed [DATA_W-1:0] fmul(input logic signed [OPND_W-1:0] a,
			input logic signed [OPND_W-1:0] b);
		logic signed [PROD_W-1:0] p;
		logic signed [PROD_W-1:0] sh;
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		p  = a * b + (PROD_W'(1) <<< (FRAC_BITS - 1));
		sh = p >>> FRAC_BITS;
		hi = PROD_W'(S32_MAX);
		lo = PROD_W'(S32_MIN);
		if (sh > hi)
			return S32_MAX;
		else if (sh < lo)
			return S32_MIN;
		else
			return sh[DATA_W-1:0];
	endfunction

endpackage

>>> hw/rtl/constant_velocity_kalman_6axis.sv
// ----------------------------------------------------------------------------
// constant_velocity_kalman_6axis
// Six independent per-axis constant-velocity Kalman filters in parallel
// lanes; the merge stage collects the six estimates into one result item.
// ----------------------------------------------------------------------------
//  channel   handshake              payload      notes
//  in        in_valid / in_ready    cvkf_in_t    six measurements, dt, restart
//  out       out_valid / out_ready  cvkf_out_t   six estimates
//  cfg       cfg_we                 cfg_data     index 0 process, 1 measure noise
//
//  A filtering item passes the multiply and sum steps, the divider (two bits
//  per cycle), the done handshake, 6 correction steps and the merge into the
//  output register. A first or restart item skips these steps: each lane
//  loads its measurement as position, and the merge follows.
//  One item is in work at a time; in_ready returns when its result enters the
//  output register, which holds while out_ready is low.
//  Reset clears all filter state to zero position/velocity, identity covariance.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_6axis import cvkf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cvkf_in_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cvkf_out_t         out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	logic              busy_q;
	logic              started_q;
	logic              out_valid_q;
	cvkf_out_t         out_q;
	logic [DATA_W-1:0] q_noise_q;
	logic [DATA_W-1:0] r_noise_q;

	logic                     accept;
	logic                     load;
	cvkf_cmd_t                cmd;
	logic [AXES-1:0]          lane_done;
	logic signed [DATA_W-1:0] meas_a [LANES];
	logic signed [DATA_W-1:0] est_a  [LANES];

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign cmd.start = accept;
	assign cmd.init  = !started_q || in_data.restart;

	assign meas_a[0] = in_data.meas_x;
	assign meas_a[1] = in_data.meas_y;
	assign meas_a[2] = in_data.meas_z;
	assign meas_a[3] = in_data.meas_roll;
	assign meas_a[4] = in_data.meas_pitch;
	assign meas_a[5] = in_data.meas_yaw;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < AXES) begin : g_on
			cvkf_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.z      (meas_a[i]),
				.dt     (in_data.step_time),
				.q      (q_noise_q),
				.r      (r_noise_q),
				.done   (lane_done[i]),
				.est    (est_a[i])
			);
		end else begin : g_off
			assign est_a[i] = '0;
		end
	end

	// merge once every lane has finished and the output register is free
	assign load = busy_q && (&lane_done) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			q_noise_q   <= FIX_ONE;
			r_noise_q   <= FIX_ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROCESS_NOISE: q_noise_q <= cfg_data;
					CFG_MEASURE_NOISE: r_noise_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				busy_q    <= 1'b1;
				started_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.est_x     <= est_a[0];
			out_q.est_y     <= est_a[1];
			out_q.est_z     <= est_a[2];
			out_q.est_roll  <= est_a[3];
			out_q.est_pitch <= est_a[4];
			out_q.est_yaw   <= est_a[5];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("item accepted but block not busy");

	a_rose_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result appeared without an item in work");

	a_load_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !busy_q)
		else $error("block still busy after result was merged");

endmodule

>>> hw/rtl/cvkf_div.sv
// ----------------------------------------------------------------------------
// cvkf_div
// Signed fixed-point divider, (num << FRAC_BITS) / den, truncated toward
// zero and saturated; two quotient bits per cycle. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module cvkf_div import cvkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic signed [DATA_W-1:0] den,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot
);

	localparam int DIV_W  = DATA_W + FRAC_BITS;
	localparam int DIV_WP = DIV_W + (DIV_W % 2);
	localparam int ITER   = DIV_WP / 2;
	localparam int CNT_W  = $clog2(ITER + 1);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DIV_WP-1:0]        qd_q;
	logic [DATA_W:0]          dsr_q;
	logic [DATA_W:0]          rem_q;
	logic                     neg_q;
	logic                     zero_q;
	logic signed [DATA_W-1:0] quot_q;

	logic [DATA_W:0]   num_mag;
	logic [DATA_W:0]   den_mag;
	logic [DATA_W+1:0] t1, t2;
	logic              b1, b2;
	logic [DATA_W:0]   r1, r2;
	logic [DIV_WP-1:0] qd_next;
	logic signed [DATA_W-1:0] fin;

	assign num_mag = num[DATA_W-1] ? (DATA_W+1)'(-{num[DATA_W-1], num}) : {1'b0, num};
	assign den_mag = den[DATA_W-1] ? (DATA_W+1)'(-{den[DATA_W-1], den}) : {1'b0, den};

	always_comb begin
		t1 = {rem_q, qd_q[DIV_WP-1]};
		b1 = t1 >= {1'b0, dsr_q};
		r1 = b1 ? (DATA_W+1)'(t1 - {1'b0, dsr_q}) : t1[DATA_W:0];
		t2 = {r1, qd_q[DIV_WP-2]};
		b2 = t2 >= {1'b0, dsr_q};
		r2 = b2 ? (DATA_W+1)'(t2 - {1'b0, dsr_q}) : t2[DATA_W:0];
		qd_next = {qd_q[DIV_WP-3:0], b1, b2};
		if (zero_q)
			fin = '0;
		else if (!neg_q)
			fin = (qd_next > DIV_WP'(S32_MAX)) ? S32_MAX : qd_next[DATA_W-1:0];
		else if (qd_next > {{(DIV_WP-DATA_W){1'b0}}, S32_MIN})
			fin = S32_MIN;
		else
			fin = DATA_W'(-qd_next[DATA_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q   <= DIV_WP'({num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}});
			rem_q  <= '0;
			dsr_q  <= den_mag;
			neg_q  <= num[DATA_W-1] ^ den[DATA_W-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			qd_q  <= qd_next;
			rem_q <= r2;
			if (cnt_q == CNT_W'(1))
				quot_q <= fin;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hw/rtl/cvkf_lane.sv
// ----------------------------------------------------------------------------
// cvkf_lane
// One axis filter: position, velocity and 2x2 covariance, updated by a
// short sequencer around one multiplier and two dividers.
// ----------------------------------------------------------------------------
module cvkf_lane import cvkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cvkf_cmd_t                cmd,
	input  logic signed [DATA_W-1:0] z,
	input  logic        [STEP_W-1:0] dt,
	input  logic        [DATA_W-1:0] q,
	input  logic        [DATA_W-1:0] r,
	output logic                     done,
	output logic signed [DATA_W-1:0] est
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_M1     = 4'd1;
	localparam logic [3:0] S_M2     = 4'd2;
	localparam logic [3:0] S_M3     = 4'd3;
	localparam logic [3:0] S_M4     = 4'd4;
	localparam logic [3:0] S_SUM    = 4'd5;
	localparam logic [3:0] S_S      = 4'd6;
	localparam logic [3:0] S_DSTART = 4'd7;
	localparam logic [3:0] S_DWAIT  = 4'd8;
	localparam logic [3:0] S_U0     = 4'd9;
	localparam logic [3:0] S_U1     = 4'd10;
	localparam logic [3:0] S_U2     = 4'd11;
	localparam logic [3:0] S_U3     = 4'd12;
	localparam logic [3:0] S_U4     = 4'd13;
	localparam logic [3:0] S_U5     = 4'd14;

	logic [3:0] st_q;
	logic       done_q;
	logic signed [DATA_W-1:0] pos_q, vel_q, cpos_q, ccross_q, crate_q;
	logic signed [DATA_W-1:0] z_q;
	logic        [STEP_W-1:0] dt_q;
	logic signed [DATA_W-1:0] m1_q, m2_q, m3_q, m4_q, t_q;
	logic signed [DATA_W-1:0] pp_q, ap_q, bp_q, cp_q, y_q, s_q;

	logic signed [DATA_W-1:0] k0, k1;
	logic                     k0_done, k1_done;
	logic signed [OPND_W-1:0] ma, mb, dt_x;
	logic signed [DATA_W-1:0] mres;
	logic signed [SUM_W-1:0]  q_x, r_x;

	assign dt_x = $signed({{(OPND_W-STEP_W){1'b0}}, dt_q});
	assign q_x  = $signed({{(SUM_W-DATA_W){1'b0}}, q});
	assign r_x  = $signed({{(SUM_W-DATA_W){1'b0}}, r});

	// one shared multiplier, operands picked by step
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_M1: begin ma = dt_x; mb = OPND_W'(vel_q); end
			S_M2: begin ma = dt_x; mb = OPND_W'(ccross_q); end
			S_M3: begin ma = dt_x; mb = OPND_W'(crate_q); end
			S_M4: begin ma = dt_x; mb = OPND_W'(m3_q); end
			S_U0: begin ma = OPND_W'(k0); mb = OPND_W'(y_q); end
			S_U1: begin ma = OPND_W'(k1); mb = OPND_W'(y_q); end
			S_U2: begin ma = OPND_W'(k0); mb = OPND_W'(ap_q); end
			S_U3: begin ma = OPND_W'(k0); mb = OPND_W'(bp_q); end
			S_U4: begin ma = OPND_W'(k1); mb = OPND_W'(bp_q); end
			default: begin ma = '0; mb = '0; end
		endcase
		mres = fmul(ma, mb);
	end

	cvkf_div u_div_k0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == S_DSTART),
		.num    (ap_q),
		.den    (s_q),
		.done   (k0_done),
		.quot   (k0)
	);

	cvkf_div u_div_k1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == S_DSTART),
		.num    (bp_q),
		.den    (s_q),
		.done   (k1_done),
		.quot   (k1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			done_q   <= 1'b0;
			pos_q    <= '0;
			vel_q    <= '0;
			cpos_q   <= FIX_ONE;
			ccross_q <= '0;
			crate_q  <= FIX_ONE;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd.start && cmd.init) begin
						pos_q    <= z;
						vel_q    <= '0;
						cpos_q   <= FIX_ONE;
						ccross_q <= '0;
						crate_q  <= FIX_ONE;
						done_q   <= 1'b1;
					end else if (cmd.start) begin
						done_q <= 1'b0;
						st_q   <= S_M1;
					end
				end
				S_M1:     st_q <= S_M2;
				S_M2:     st_q <= S_M3;
				S_M3:     st_q <= S_M4;
				S_M4:     st_q <= S_SUM;
				S_SUM:    st_q <= S_S;
				S_S:      st_q <= S_DSTART;
				S_DSTART: st_q <= S_DWAIT;
				S_DWAIT: begin
					if (k0_done && k1_done)
						st_q <= S_U0;
				end
				S_U0: st_q <= S_U1;
				S_U1: begin
					pos_q <= sat_sum(SUM_W'(pp_q) + SUM_W'(t_q));
					st_q  <= S_U2;
				end
				S_U2: begin
					vel_q <= sat_sum(SUM_W'(vel_q) + SUM_W'(t_q));
					st_q  <= S_U3;
				end
				S_U3: begin
					cpos_q <= sat_sum(SUM_W'(ap_q) - SUM_W'(t_q));
					st_q   <= S_U4;
				end
				S_U4: begin
					ccross_q <= sat_sum(SUM_W'(bp_q) - SUM_W'(t_q));
					st_q     <= S_U5;
				end
				S_U5: begin
					crate_q <= sat_sum(SUM_W'(cp_q) - SUM_W'(t_q));
					done_q  <= 1'b1;
					st_q    <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// working values of the current item
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && cmd.start) begin
			z_q  <= z;
			dt_q <= dt;
		end
		case (st_q)
			S_M1: m1_q <= mres;
			S_M2: m2_q <= mres;
			S_M3: m3_q <= mres;
			S_M4: begin
				m4_q <= mres;
				pp_q <= sat_sum(SUM_W'(pos_q) + SUM_W'(m1_q));
				bp_q <= sat_sum(SUM_W'(ccross_q) + SUM_W'(m3_q));
				cp_q <= sat_sum(SUM_W'(crate_q) + q_x);
			end
			S_SUM: begin
				ap_q <= sat_sum(SUM_W'(cpos_q) + SUM_W'(m2_q) + SUM_W'(m2_q)
					+ SUM_W'(m4_q) + q_x);
				y_q  <= sat_sum(SUM_W'(z_q) - SUM_W'(pp_q));
			end
			S_S: s_q <= sat_sum(SUM_W'(ap_q) + r_x);
			S_U0, S_U1, S_U2, S_U3, S_U4: t_q <= mres;
			default: ;
		endcase
	end

	assign done = done_q;
	assign est  = pos_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-axis constant-velocity Kalman filter:
// a queue-fed driver, a checking monitor and a per-axis fixed-point predictor,
// run through several noise settings with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import cvkf_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	cvkf_in_t          in_data;
	logic              out_valid;
	logic              out_ready;
	cvkf_out_t         out_data;
	logic              cfg_we;
	logic              cfg_index;
	logic [DATA_W-1:0] cfg_data;

	constant_velocity_kalman_6axis dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;
	localparam longint UNITY = 64'sd1 << FRAC_BITS;

	cvkf_in_t  pending_items[$];
	cvkf_out_t expected_est[$];
	int        errors = 0;
	bit        calm = 0;
	bit        hold_req = 0;
	int        hold_left = 0;
	int        send_gap = 0;
	int        recv_gap = 0;

	// filter state kept by the bench
	longint noise_q, noise_r;
	longint pos[LANES], vel[LANES], cov_a[LANES], cov_b[LANES], cov_c[LANES];
	bit     filter_live;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint sat32(longint x);
		if (x > MAX32) return MAX32;
		if (x < MIN32) return MIN32;
		return x;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sat32((a * b + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	function automatic longint qdiv(longint num, longint den);
		if (den == 0) return 0;
		return sat32((num * UNITY) / den);
	endfunction

	function automatic void clear_filter();
		for (int i = 0; i < LANES; i++) begin
			pos[i] = 0; vel[i] = 0; cov_a[i] = UNITY; cov_b[i] = 0; cov_c[i] = UNITY;
		end
	endfunction

	function automatic cvkf_out_t filter_step(cvkf_in_t it);
		longint z[LANES];
		longint est[LANES];
		longint dt, pp, dtb, ap, bp, cp, s, k0, k1, y;
		cvkf_out_t res;
		z[0] = longint'(it.meas_x); z[1] = longint'(it.meas_y);
		z[2] = longint'(it.meas_z); z[3] = longint'(it.meas_roll);
		z[4] = longint'(it.meas_pitch); z[5] = longint'(it.meas_yaw);
		dt = longint'(it.step_time);
		if (!filter_live || it.restart) begin
			clear_filter();
			for (int i = 0; i < AXES; i++) begin
				pos[i] = z[i];
				est[i] = z[i];
			end
			for (int i = AXES; i < LANES; i++) est[i] = 0;
			filter_live = 1;
		end else begin
			for (int i = AXES; i < LANES; i++) est[i] = 0;
			for (int i = 0; i < AXES; i++) begin
				pp  = sat32(pos[i] + qmul(dt, vel[i]));
				dtb = qmul(dt, cov_b[i]);
				ap  = sat32(cov_a[i] + dtb + dtb + qmul(dt, qmul(dt, cov_c[i])) + noise_q);
				bp  = sat32(cov_b[i] + qmul(dt, cov_c[i]));
				cp  = sat32(cov_c[i] + noise_q);
				s   = sat32(ap + noise_r);
				k0  = qdiv(ap, s);
				k1  = qdiv(bp, s);
				y   = sat32(z[i] - pp);
				pos[i]   = sat32(pp + qmul(k0, y));
				vel[i]   = sat32(vel[i] + qmul(k1, y));
				cov_a[i] = sat32(ap - qmul(k0, ap));
				cov_b[i] = sat32(bp - qmul(k0, bp));
				cov_c[i] = sat32(cp - qmul(k1, bp));
				est[i]   = pos[i];
			end
		end
		res.est_x = DATA_W'(est[0]); res.est_y = DATA_W'(est[1]);
		res.est_z = DATA_W'(est[2]); res.est_roll = DATA_W'(est[3]);
		res.est_pitch = DATA_W'(est[4]); res.est_yaw = DATA_W'(est[5]);
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_est.push_back(filter_step(in_data));
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_data  <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= 300;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// monitor
	always @(posedge clk) begin
		cvkf_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_est.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, out_data);
					errors++;
				end else begin
					want = expected_est.pop_front();
					if (out_data.est_x !== want.est_x)
						$display("%0t: est_x expected %h actual %h", $time,
							want.est_x, out_data.est_x);
					if (out_data.est_y !== want.est_y)
						$display("%0t: est_y expected %h actual %h", $time,
							want.est_y, out_data.est_y);
					if (out_data.est_z !== want.est_z)
						$display("%0t: est_z expected %h actual %h", $time,
							want.est_z, out_data.est_z);
					if (out_data.est_roll !== want.est_roll)
						$display("%0t: est_roll expected %h actual %h", $time,
							want.est_roll, out_data.est_roll);
					if (out_data.est_pitch !== want.est_pitch)
						$display("%0t: est_pitch expected %h actual %h", $time,
							want.est_pitch, out_data.est_pitch);
					if (out_data.est_yaw !== want.est_yaw)
						$display("%0t: est_yaw expected %h actual %h", $time,
							want.est_yaw, out_data.est_yaw);
					if (out_data !== want) errors++;
				end
			end
			if (hold_req || hold_left > 1) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap  <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					recv_gap <= $urandom_range(1, 7);
			end
		end
	end

	function automatic logic [31:0] rand_meas(longint base);
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom();
			default: return 32'(base + $signed($urandom_range(0, 32'h3ffff)) - 32'h1ffff);
		endcase
	endfunction

	function automatic cvkf_in_t rand_item(longint base);
		cvkf_in_t it;
		it.meas_x = rand_meas(base); it.meas_y = rand_meas(-base);
		it.meas_z = rand_meas(base / 2); it.meas_roll = rand_meas(0);
		it.meas_pitch = rand_meas(base * 3); it.meas_yaw = rand_meas(-base / 4);
		case ($urandom_range(0, 7))
			0: it.step_time = STEP_W'($urandom());
			1: it.step_time = 0;
			default: it.step_time = STEP_W'($urandom_range(1, 24'h4000));
		endcase
		it.restart = ($urandom_range(0, 29) == 0);
		return it;
	endfunction

	function automatic cvkf_in_t fixed_item(logic [31:0] m, logic [STEP_W-1:0] dt, logic rs);
		cvkf_in_t it;
		it.meas_x = m; it.meas_y = ~m; it.meas_z = m; it.meas_roll = ~m;
		it.meas_pitch = m; it.meas_yaw = ~m;
		it.step_time = dt;
		it.restart = rs;
		return it;
	endfunction

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !in_valid && expected_est.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_noise(logic [31:0] q, logic [31:0] r);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= CFG_PROCESS_NOISE; cfg_data <= q;
		@(posedge clk);
		cfg_index <= CFG_MEASURE_NOISE; cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		noise_q = longint'(q);
		noise_r = longint'(r);
	endtask

	task automatic random_phase(int n);
		longint track;
		track = 0;
		pending_items.push_back(fixed_item($urandom(), STEP_W'($urandom()), 1'b1));
		for (int i = 0; i < n; i++) begin
			track += $urandom_range(0, 2000);
			pending_items.push_back(rand_item(track));
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_index = CFG_PROCESS_NOISE; cfg_data = '0;
		noise_q = UNITY; noise_r = UNITY; filter_live = 0;
		clear_filter();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: first item at extremes, restarts, step extremes
		pending_items.push_back(fixed_item(32'h7fffffff, 24'hffffff, 1'b0));
		pending_items.push_back(fixed_item(32'h80000000, 24'hffffff, 1'b0));
		pending_items.push_back(fixed_item(32'h00000000, 24'h000000, 1'b0));
		pending_items.push_back(fixed_item(32'h80000000, 24'h010000, 1'b1));
		pending_items.push_back(fixed_item(32'h7fffffff, 24'h010000, 1'b0));
		pending_items.push_back(fixed_item(32'h00010000, 24'hffffff, 1'b0));
		pending_items.push_back(fixed_item(32'hffff0000, 24'h000001, 1'b0));
		pending_items.push_back(fixed_item(32'h12345678, 24'h000000, 1'b1));
		pending_items.push_back(fixed_item(32'h12355678, 24'h008000, 1'b0));
		pending_items.push_back(fixed_item(32'h12365678, 24'h008000, 1'b0));
		wait_idle();

		// zero noise: covariance collapses and the divisor reaches zero
		set_noise(32'h0, 32'h0);
		pending_items.push_back(fixed_item(32'h00050000, 24'h000000, 1'b1));
		pending_items.push_back(fixed_item(32'h00060000, 24'h000000, 1'b0));
		pending_items.push_back(fixed_item(32'h00070000, 24'h000000, 1'b0));
		pending_items.push_back(fixed_item(32'h00080000, 24'h020000, 1'b0));
		pending_items.push_back(fixed_item(32'hfff00000, 24'hffffff, 1'b0));
		wait_idle();

		set_noise(32'hffffffff, 32'hffffffff);
		pending_items.push_back(fixed_item(32'h7fffffff, 24'h010000, 1'b1));
		pending_items.push_back(fixed_item(32'h80000000, 24'hffffff, 1'b0));
		pending_items.push_back(fixed_item(32'h7fffffff, 24'hffffff, 1'b0));
		wait_idle();

		// random phases over several settings, one with a long output stall
		set_noise(32'h00010000, 32'h00010000);
		hold_req <= 1;
		@(posedge clk);
		hold_req <= 0;
		random_phase(150);
		set_noise(32'h0, 32'h0);
		random_phase(120);
		set_noise(32'hffffffff, 32'h0);
		random_phase(100);
		set_noise($urandom(), $urandom());
		random_phase(130);
		set_noise($urandom_range(0, 32'h20000), $urandom_range(0, 32'h80000));
		random_phase(130);
		calm = 1;
		set_noise(32'h0, 32'hffffffff);
		random_phase(120);

		repeat (60) @(posedge clk);
		if (expected_est.size() != 0) errors++;
		if (errors == 0)
			$display("constant_velocity_kalman_6axis verification clean");
		else
			$display("constant_velocity_kalman_6axis verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("constant_velocity_kalman_6axis verification failed");
		$finish;
	end

endmodule
